// ----- design/ded_pkg.sv -----
// ----------------------------------------------------------------------------
// ded_pkg
// Shared widths, types and arithmetic helpers of the dual distance block.
// ----------------------------------------------------------------------------
package ded_pkg;

   localparam int COORD_W    = 16;  // signed Q4.12 coordinate
   localparam int MAG_W      = 16;  // magnitude of a Q5.12 difference
   localparam int SQ_W       = 32;  // unsigned Q8.24 square
   localparam int ACC_W      = 41;  // unsigned Q17.24 sum of squares
   localparam int DEG_W      = 16;
   localparam int DSUM_W     = 17;
   localparam int DIST_W     = 21;  // unsigned Q9.12 distance
   localparam int ROOT_STEPS = (ACC_W + 1) / 2;
   localparam int STEP_W     = $clog2(ROOT_STEPS);

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_ROOT,
      ST_SHOW
   } ded_state_type;

   typedef struct packed {
      logic load;   // capture an input transfer into the square stage
      logic fold;   // add the square stage into the accumulators
      logic start;  // hand the final sums to the root units, clear sums
      logic step;   // advance the root units by one digit
   } ded_cmd_type;

   typedef struct packed {
      logic [ACC_W-1:0] x;     // remainder
      logic [ACC_W-1:0] res;   // partial root
      logic [ACC_W-1:0] rbit;  // current trial bit
   } root_type;

   function automatic logic [ACC_W-1:0] sat_add(input logic [ACC_W-1:0] acc,
                                                input logic [SQ_W-1:0]  add);
      logic [ACC_W:0] sum;
      sum = {1'b0, acc} + (ACC_W+1)'(add);
      return sum[ACC_W] ? {ACC_W{1'b1}} : sum[ACC_W-1:0];
   endfunction

   function automatic logic [SQ_W-1:0] sq_diff(input logic [COORD_W-1:0] a,
                                                input logic [COORD_W-1:0] b);
      logic [COORD_W:0] diff;
      logic [COORD_W:0] mag;
      diff = {a[COORD_W-1], a} - {b[COORD_W-1], b};
      mag  = diff[COORD_W] ? (~diff + 1'b1) : diff;
      return mag[MAG_W-1:0] * mag[MAG_W-1:0];
   endfunction

   // One digit of the restoring square root.
   function automatic root_type root_step(input root_type r);
      root_type       n;
      logic [ACC_W:0] trial;
      trial  = {1'b0, r.res} + {1'b0, r.rbit};
      n      = r;
      if ({1'b0, r.x} >= trial) begin
         n.x   = r.x - trial[ACC_W-1:0];
         n.res = (r.res >> 1) + r.rbit;
      end else begin
         n.res = r.res >> 1;
      end
      n.rbit = r.rbit >> 2;
      return n;
   endfunction

endpackage

// ----- design/dual_euclidean_distance_top.sv -----
// ----------------------------------------------------------------------------
// dual_euclidean_distance_top
// Euclidean distances of two node embeddings plus the node degree sum.
// ----------------------------------------------------------------------------
// Usage:
//  - The req_ channel carries one coordinate pair per transfer for each of
//    the two embeddings (signed Q4.12), with req_last marking the final
//    coordinate. The degrees returned are those of the last transfer.
//  - The rsp_ channel returns one result per vector pair: both distances as
//    unsigned Q9.12 floor square roots and the degree sum.
//  - Throughput: one transfer per cycle unless a last item waits. The square
//    of each difference is registered, then folded into a saturating 41-bit sum.
//  - The root units resolve one result bit per cycle; the result is valid
//    once the last transfer is folded in and every root bit is resolved.
//  - The next vectors accumulate while a root runs or a result waits. Only
//    a second last transfer waits until the root units are free.
//  - A stalled rsp_ready holds the result; input keeps streaming until the
//    next last item reaches the square stage.
//  - Reset clears the sums, the control state and drops any pending result.
// ----------------------------------------------------------------------------
module dual_euclidean_distance_top
   import ded_pkg::*;
(
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_ready,
   input  logic [COORD_W-1:0] req_first_v,
   input  logic [COORD_W-1:0] req_first_u,
   input  logic [COORD_W-1:0] req_second_v,
   input  logic [COORD_W-1:0] req_second_u,
   input  logic [DEG_W-1:0]   req_degree_v,
   input  logic [DEG_W-1:0]   req_degree_u,
   input  logic               req_last,
   output logic               rsp_valid,
   input  logic               rsp_ready,
   output logic [DIST_W-1:0]  rsp_first_distance,
   output logic [DIST_W-1:0]  rsp_second_distance,
   output logic [DSUM_W-1:0]  rsp_degree_sum
);

   ded_cmd_type cmd;

   // sequence the transfers and the root digits
   ded_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_last  (req_last),
      .req_ready (req_ready),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .cmd       (cmd)
   );

   // square, accumulate, take roots
   ded_datapath u_datapath (
      .clock               (clock),
      .reset               (reset),
      .cmd                 (cmd),
      .req_first_v         (req_first_v),
      .req_first_u         (req_first_u),
      .req_second_v        (req_second_v),
      .req_second_u        (req_second_u),
      .req_degree_v        (req_degree_v),
      .req_degree_u        (req_degree_u),
      .rsp_first_distance  (rsp_first_distance),
      .rsp_second_distance (rsp_second_distance),
      .rsp_degree_sum      (rsp_degree_sum)
   );

endmodule

// ----- design/ded_ctrl.sv -----
// ----------------------------------------------------------------------------
// ded_ctrl
// Handshake control and root sequencer of the dual distance block.
// ----------------------------------------------------------------------------
module ded_ctrl
   import ded_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   input  logic        req_last,
   output logic        req_ready,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output ded_cmd_type cmd
);

   ded_state_type     state_ff, state_in;
   logic [STEP_W-1:0] step_ff, step_in;
   logic              s1_valid_ff, s1_valid_in;
   logic              s1_last_ff, s1_last_in;
   logic              root_free;
   logic              last_step;

   assign root_free = (state_ff == ST_IDLE) || ((state_ff == ST_SHOW) && rsp_ready);
   assign last_step = (step_ff == STEP_W'(ROOT_STEPS - 1));

   // outputs
   always_comb begin
      cmd.fold  = s1_valid_ff && (!s1_last_ff || root_free);
      cmd.start = cmd.fold && s1_last_ff;
      cmd.step  = (state_ff == ST_ROOT);
      req_ready = !s1_valid_ff || cmd.fold;
      cmd.load  = req_valid && req_ready;
      rsp_valid = (state_ff == ST_SHOW);
   end

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (cmd.start) state_in = ST_ROOT;
         end
         ST_ROOT: begin
            if (last_step) state_in = ST_SHOW;
         end
         ST_SHOW: begin
            if (rsp_ready) state_in = cmd.start ? ST_ROOT : ST_IDLE;
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_comb begin
      step_in = step_ff;
      if (cmd.start) step_in = '0;
      else if (cmd.step && !last_step) step_in = step_ff + 1'b1;

      s1_valid_in = s1_valid_ff;
      if (cmd.load) s1_valid_in = 1'b1;
      else if (cmd.fold) s1_valid_in = 1'b0;

      s1_last_in = cmd.load ? req_last : s1_last_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff    <= ST_IDLE;
         step_ff     <= '0;
         s1_valid_ff <= 1'b0;
         s1_last_ff  <= 1'b0;
      end else begin
         state_ff    <= state_in;
         step_ff     <= step_in;
         s1_valid_ff <= s1_valid_in;
         s1_last_ff  <= s1_last_in;
      end
   end

   a_start_when_free: assert property (@(posedge clock) disable iff (reset)
      cmd.start |-> root_free)
      else $error("root started while busy");

   a_step_in_range: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_ROOT) |-> (step_ff < STEP_W'(ROOT_STEPS)))
      else $error("root step count out of range");

   a_idle_after_transfer: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_ready && !cmd.start) |=> (state_ff == ST_IDLE))
      else $error("no return to idle after result transfer");

   a_stall_only_on_last: assert property (@(posedge clock) disable iff (reset)
      !req_ready |-> (s1_valid_ff && s1_last_ff && !root_free))
      else $error("input stalled without a pending last item");

endmodule

// ----- design/ded_datapath.sv -----
// ----------------------------------------------------------------------------
// ded_datapath
// Square stage, saturating accumulators and two digit-serial root units.
// ----------------------------------------------------------------------------
module ded_datapath
   import ded_pkg::*;
(
   input  logic                clock,
   input  logic                reset,
   input  ded_cmd_type         cmd,
   input  logic [COORD_W-1:0]  req_first_v,
   input  logic [COORD_W-1:0]  req_first_u,
   input  logic [COORD_W-1:0]  req_second_v,
   input  logic [COORD_W-1:0]  req_second_u,
   input  logic [DEG_W-1:0]    req_degree_v,
   input  logic [DEG_W-1:0]    req_degree_u,
   output logic [DIST_W-1:0]   rsp_first_distance,
   output logic [DIST_W-1:0]   rsp_second_distance,
   output logic [DSUM_W-1:0]   rsp_degree_sum
);

   logic [SQ_W-1:0]   sq1_ff, sq2_ff;
   logic [DSUM_W-1:0] dsum_ff, dsum_out_ff;
   logic [ACC_W-1:0]  acc1_ff, acc1_in, acc2_ff, acc2_in;
   logic [ACC_W-1:0]  sum1, sum2;
   root_type          r1_ff, r1_in, r2_ff, r2_in;

   assign sum1 = sat_add(acc1_ff, sq1_ff);
   assign sum2 = sat_add(acc2_ff, sq2_ff);

   always_comb begin
      acc1_in = acc1_ff;
      acc2_in = acc2_ff;
      if (cmd.start) begin
         acc1_in = '0;
         acc2_in = '0;
      end else if (cmd.fold) begin
         acc1_in = sum1;
         acc2_in = sum2;
      end

      r1_in = r1_ff;
      r2_in = r2_ff;
      if (cmd.start) begin
         r1_in.x    = sum1;
         r1_in.res  = '0;
         r1_in.rbit = ACC_W'(1) << (2 * (ROOT_STEPS - 1));
         r2_in.x    = sum2;
         r2_in.res  = '0;
         r2_in.rbit = ACC_W'(1) << (2 * (ROOT_STEPS - 1));
      end else if (cmd.step) begin
         r1_in = root_step(r1_ff);
         r2_in = root_step(r2_ff);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         acc1_ff <= '0;
         acc2_ff <= '0;
      end else begin
         acc1_ff <= acc1_in;
         acc2_ff <= acc2_in;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.load) begin
         sq1_ff  <= sq_diff(req_first_v, req_first_u);
         sq2_ff  <= sq_diff(req_second_v, req_second_u);
         dsum_ff <= {1'b0, req_degree_v} + {1'b0, req_degree_u};
      end
      if (cmd.start) dsum_out_ff <= dsum_ff;
      r1_ff <= r1_in;
      r2_ff <= r2_in;
   end

   assign rsp_first_distance  = r1_ff.res[DIST_W-1:0];
   assign rsp_second_distance = r2_ff.res[DIST_W-1:0];
   assign rsp_degree_sum      = dsum_out_ff;

endmodule
